// File: hw/rtl/bni_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bni_pkg
// shared types and constants of the batch normalization inference unit
// ----------------------------------------------------------------------------
package bni_pkg;

  localparam int unsigned ChanW   = 10;
  localparam int unsigned DataW   = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned InnerW  = 24;
  localparam int unsigned CountW  = 11;
  localparam int unsigned SizeW   = 25;
  localparam int unsigned EpsW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 25;

  localparam logic [CfgIdxW-1:0] CfgChannelCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInnerSize    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEpsilon      = 2'd2;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpSample = 1'b1;

  localparam logic signed [DataW-1:0] DMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] DMin = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DataW-1:0] gamma;
    logic signed [DataW-1:0] beta;
    logic signed [DataW-1:0] mean;
    logic signed [DataW-1:0] inv_std;
  } chan_param_t;

  typedef struct packed {
    logic             we;
    logic [ChanW-1:0] addr;
    chan_param_t      data;
  } param_wr_t;

  typedef enum logic [1:0] {
    StIdle,
    StSqrt,
    StWrite
  } ctrl_state_e;

  // clip a 65 bit signed value to the data range
  function automatic logic [DataW:0] sat65(input logic signed [64:0] v);
    logic [DataW:0] r;
    if (v > 65'(signed'(DMax))) r = {1'b1, DMax};
    else if (v < 65'(signed'(DMin))) r = {1'b1, DMin};
    else r = {1'b0, v[DataW-1:0]};
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bni_inv_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bni_inv_sqrt
// bit serial search for floor(sqrt(2^48 / v)) after a restoring divide, one result bit per cycle
// ----------------------------------------------------------------------------
module bni_inv_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [32:0] value_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  // limit = 2^48 / v needs a divider; restoring divide first, then the search
  logic [48:0] rem_q, rem_d;
  logic [48:0] quo_q, quo_d;
  logic [32:0] div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        dphase_q, dphase_d;
  logic        busy_q, busy_d;
  logic        zero_q, zero_d;
  logic [31:0] r_q, r_d;
  logic        done_q, done_d;
  logic [49:0] rem_sh;
  logic [31:0] trial;
  logic [63:0] sq;

  always_comb begin
    rem_sh  = {rem_q, quo_q[48]};
    trial   = r_q | (32'd1 << cnt_q[4:0]);
    sq      = 64'(trial) * 64'(trial);
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    dphase_d = dphase_q;
    busy_d  = busy_q;
    zero_d  = zero_q;
    r_d     = r_q;
    done_d  = 1'b0;
    if (start_i) begin
      busy_d   = 1'b1;
      dphase_d = 1'b1;
      div_d    = value_i;
      zero_d   = (value_i == '0);
      rem_d    = '0;
      quo_d    = 49'h1_0000_0000_0000;
      cnt_d    = 6'd48;
      r_d      = '0;
    end else if (busy_q) begin
      if (dphase_q) begin
        if (rem_sh >= 50'(div_q)) begin
          rem_d = 49'(rem_sh - 50'(div_q));
          quo_d = {quo_q[47:0], 1'b1};
        end else begin
          rem_d = rem_sh[48:0];
          quo_d = {quo_q[47:0], 1'b0};
        end
        if (cnt_q == 6'd0) begin
          dphase_d = 1'b0;
          cnt_d    = 6'd31;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end else begin
        if (sq <= 64'(quo_q)) r_d = trial;
        if (cnt_q == 6'd0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      dphase_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      done_q   <= done_d;
      dphase_q <= dphase_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    div_q  <= div_d;
    zero_q <= zero_d;
    r_q    <= r_d;
  end

  always_comb begin
    done_o = done_q;
    if (zero_q || r_q[31]) root_o = 32'h7FFF_FFFF;
    else root_o = r_q;
  end

endmodule
`default_nettype wire

// File: hw/rtl/bni_param_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bni_param_mem
// per channel parameter memory, one write and one registered read port
// ----------------------------------------------------------------------------
module bni_param_mem (
  input  wire logic                      clk_i,
  input  wire bni_pkg::param_wr_t        wr_i,
  input  wire logic [bni_pkg::ChanW-1:0] rd_addr_i,
  output bni_pkg::chan_param_t           rd_data_o
);

  bni_pkg::chan_param_t mem [2**bni_pkg::ChanW];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) mem[wr_i.addr] <= wr_i.data;
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/bni_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bni_datapath
// three stage normalize pipeline: subtract mean, scale by inv_std, then gamma and beta
// ----------------------------------------------------------------------------
module bni_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic signed [bni_pkg::DataW-1:0]  x_i,
  input  wire logic [bni_pkg::ChanW-1:0]         chan_i,
  input  wire bni_pkg::chan_param_t              prm_i,
  output logic                                   valid_o,
  output logic [bni_pkg::DataW-1:0]              y_o,
  output logic [bni_pkg::ChanW-1:0]              chan_o,
  output logic                                   sat_o
);

  logic [2:0] vld_q;
  logic signed [31:0] d_q, n_q, g1_q, g2_q, b1_q, b2_q, inv_q;
  logic [9:0]  c1_q, c2_q, c3_q;
  logic        f1_q, f2_q, f3_q;
  logic [31:0] y_q;
  logic [32:0] s1, s2, s3;
  logic signed [64:0] p1, p2, sum;

  always_comb begin
    s1  = bni_pkg::sat65(65'(x_i) - 65'(prm_i.mean));
    p1  = 65'(64'(d_q) * 64'(inv_q)) >>> bni_pkg::FracW;
    s2  = bni_pkg::sat65(p1);
    p2  = 65'(64'(n_q) * 64'(g2_q)) >>> bni_pkg::FracW;
    sum = p2 + 65'(b2_q);
    s3  = bni_pkg::sat65(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    d_q   <= s1[31:0];
    f1_q  <= s1[32];
    inv_q <= prm_i.inv_std;
    g1_q  <= prm_i.gamma;
    b1_q  <= prm_i.beta;
    c1_q  <= chan_i;
    n_q   <= s2[31:0];
    f2_q  <= f1_q | s2[32];
    g2_q  <= g1_q;
    b2_q  <= b1_q;
    c2_q  <= c1_q;
    y_q   <= s3[31:0];
    f3_q  <= f2_q | s3[32];
    c3_q  <= c2_q;
  end

  assign valid_o = vld_q[2];
  assign y_o     = y_q;
  assign chan_o  = c3_q;
  assign sat_o   = f3_q;

endmodule
`default_nettype wire

// File: hw/rtl/batch_norm_inference_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// batch_norm_inference_unit
// per channel batch normalization in Q16.16 with parameter memory
// ----------------------------------------------------------------------------
// usage
//   s_axis: one beat per item; tdata = sample_value, variance, mean, beta,
//   gamma, channel_index (see port); tuser = opcode (0 load, 1 sample)
//   m_axis: one beat per sample with the result, channel and clip flag
//   cfg: write enable, index and data; write only while idle
// sample and load flow
//   a sample is registered at the input with the parameter memory read,
//   passes three pipeline stages and the output register; the block
//   handles one sample at a time, so the next beat waits for the result
//   a load holds off the input during 49 divide steps and 32 root search
//   steps of the reciprocal square root unit, the registered hand-over of
//   the root, then the memory write
// reset
//   position counters clear, control and config registers take their
//   defaults; parameter memory is undefined until each channel is loaded
// stall
//   a result waits in the output register until m_axis_tready; the next
//   beat is not taken before that
// ----------------------------------------------------------------------------
module batch_norm_inference_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [24:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // channel_index[9:0], gamma[41:10], beta[73:42], mean[105:74],
  // variance[137:106], sample[169:138], zero fill to 176
  input  wire logic [175:0] s_axis_tdata,
  // opcode
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_value[31:0], out_channel[41:32], zero fill to 48
  output logic [47:0]       m_axis_tdata,
  // saturated
  output logic              m_axis_tuser
);

  logic [10:0] ccount_q;
  logic [24:0] isize_q;
  logic [15:0] eps_q;
  logic [9:0]  cpos_q;
  logic [23:0] ipos_q;

  bni_pkg::ctrl_state_e st_q, st_d;
  logic        busy_q, busy_d;
  logic        rd_pend_q;
  logic        rd_pend_d;
  logic [31:0] x_q;
  logic [9:0]  lch_q, sch_q;
  logic [31:0] lg_q, lb_q, lm_q;
  logic        accept, is_load, is_samp, sqrt_start;
  logic        sqrt_done;
  logic [31:0] root;
  bni_pkg::param_wr_t   wr;
  bni_pkg::chan_param_t prm;
  logic        dp_v, dp_sat;
  logic [31:0] dp_y;
  logic [9:0]  dp_c;
  logic        ov_q;
  logic [47:0] od_q;
  logic        ou_q;
  logic [10:0] cnt_eff;
  logic [24:0] isz_eff;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign is_load = accept && (s_axis_tuser == bni_pkg::OpLoad);
  assign is_samp = accept && (s_axis_tuser == bni_pkg::OpSample);
  assign sqrt_start = is_load;

  always_comb begin
    st_d = st_q;
    busy_d = busy_q;
    rd_pend_d = is_samp;
    s_axis_tready = (st_q == bni_pkg::StIdle) && !busy_q && !ov_q;
    wr = '0;
    case (st_q)
      bni_pkg::StIdle: begin
        if (is_load) st_d = bni_pkg::StSqrt;
        if (is_samp) busy_d = 1'b1;
        if (dp_v) busy_d = 1'b0;
      end
      bni_pkg::StSqrt: if (sqrt_done) st_d = bni_pkg::StWrite;
      bni_pkg::StWrite: begin
        wr.we = 1'b1;
        wr.addr = lch_q;
        wr.data = '{gamma: lg_q, beta: lb_q, mean: lm_q, inv_std: root};
        st_d = bni_pkg::StIdle;
      end
      default: st_d = bni_pkg::StIdle;
    endcase
  end

  always_comb begin
    cnt_eff = (ccount_q == '0) ? 11'd1 : ((ccount_q > 11'd1024) ? 11'd1024 : ccount_q);
    isz_eff = (isize_q == '0) ? 25'd1 : ((isize_q > 25'h100_0000) ? 25'h100_0000 : isize_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= bni_pkg::StIdle;
      busy_q <= 1'b0;
      rd_pend_q <= 1'b0;
      ccount_q <= 11'd1;
      isize_q <= 25'd1;
      eps_q <= 16'd66;
      cpos_q <= '0;
      ipos_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      busy_q <= busy_d;
      rd_pend_q <= rd_pend_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          bni_pkg::CfgChannelCount: ccount_q <= cfg_data_i[10:0];
          bni_pkg::CfgInnerSize:    isize_q <= cfg_data_i;
          bni_pkg::CfgEpsilon:      eps_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (is_load) begin
        cpos_q <= '0;
        ipos_q <= '0;
      end else if (is_samp) begin
        if (25'(ipos_q) + 25'd1 >= isz_eff) begin
          ipos_q <= '0;
          if (11'(cpos_q) + 11'd1 >= cnt_eff) cpos_q <= '0;
          else cpos_q <= cpos_q + 10'd1;
        end else begin
          ipos_q <= ipos_q + 24'd1;
        end
      end
      if (dp_v) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_load) begin
      lch_q <= s_axis_tdata[9:0];
      lg_q  <= s_axis_tdata[41:10];
      lb_q  <= s_axis_tdata[73:42];
      lm_q  <= s_axis_tdata[105:74];
    end
    if (is_samp) begin
      x_q   <= s_axis_tdata[169:138];
      sch_q <= cpos_q;
    end
    if (dp_v) begin
      od_q <= {6'd0, dp_c, dp_y};
      ou_q <= dp_sat;
    end
  end

  bni_inv_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (33'(s_axis_tdata[137:106]) + 33'(eps_q)),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  bni_param_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (cpos_q),
    .rd_data_o (prm)
  );

  bni_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_pend_q),
    .x_i     (x_q),
    .chan_i  (sch_q),
    .prm_i   (prm),
    .valid_o (dp_v),
    .y_o     (dp_y),
    .chan_o  (dp_c),
    .sat_o   (dp_sat)
  );

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready) else $error("beat taken while sample in flight");
  a_write_after_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> $past(st_q == bni_pkg::StSqrt)) else $error("write without root");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_v |-> !ov_q) else $error("result overrun");
`endif

endmodule
`default_nettype wire

// File: sim/batch_norm_inference_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batch_norm_inference_unit_tb
// drives load and sample beats with random idling on both stream sides and
// compares every result beat against a built-in fixed point normalizer
// ----------------------------------------------------------------------------
module batch_norm_inference_unit_tb;

  typedef struct packed {
    logic signed [31:0] value;
    logic [9:0]         chan;
    logic               sat;
  } norm_res_t;

  typedef struct {
    logic               op;
    logic [9:0]         ch;
    logic signed [31:0] gam;
    logic signed [31:0] bet;
    logic signed [31:0] mu;
    logic [31:0]        vr;
    logic signed [31:0] x;
    logic               known;
    norm_res_t          res;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_index_i = '0;
  logic [24:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;

  batch_norm_inference_unit DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  logic signed [63:0] mean_mem [1024];
  logic signed [63:0] istd_mem [1024];
  logic signed [63:0] gain_mem [1024];
  logic signed [63:0] bias_mem [1024];
  logic [10:0] chan_cnt;
  logic [24:0] inner_sz;
  logic [15:0] eps;
  int unsigned chan_pos, inner_pos;
  norm_res_t   pending_q [$];
  int          errors = 0;
  int          send_idle = 0, recv_stall = 0;

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v, inout bit f);
    if (v > 64'sd2147483647) begin f = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin f = 1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic logic signed [63:0] fl16(input logic signed [63:0] v);
    return v >>> 16;
  endfunction

  function automatic logic signed [63:0] recip_sqrt(input logic [63:0] v);
    logic [63:0] lim, r, t;
    if (v == 0) return 64'sd2147483647;
    lim = (64'd1 << 48) / v;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= lim) r = t;
    end
    if (r > 64'd2147483647) return 64'sd2147483647;
    return r;
  endfunction

  task automatic normalize(input logic op, input logic [9:0] ch, input logic signed [31:0] g,
                           input logic signed [31:0] b, input logic signed [31:0] mu,
                           input logic [31:0] vr, input logic signed [31:0] x,
                           output bit has_res, output norm_res_t r);
    logic signed [63:0] d, n, y;
    int unsigned isz, cnt, c;
    bit f;
    has_res = 0;
    if (op == bni_pkg::OpLoad) begin
      gain_mem[ch] = g; bias_mem[ch] = b; mean_mem[ch] = mu;
      istd_mem[ch] = recip_sqrt(64'(vr) + 64'(eps));
      chan_pos = 0; inner_pos = 0;
      return;
    end
    f = 0; c = chan_pos;
    d = clip32(64'(x) - mean_mem[c], f);
    n = clip32(fl16(d * istd_mem[c]), f);
    y = clip32(fl16(n * gain_mem[c]) + bias_mem[c], f);
    r.value = y[31:0]; r.chan = c[9:0]; r.sat = f;
    has_res = 1;
    isz = (inner_sz == 0) ? 1 : (inner_sz > 25'h1000000 ? 32'h1000000 : inner_sz);
    cnt = (chan_cnt == 0) ? 1 : (chan_cnt > 1024 ? 1024 : chan_cnt);
    if (inner_pos + 1 >= isz) begin
      inner_pos = 0;
      chan_pos = (chan_pos + 1 >= cnt) ? 0 : ((chan_pos + 1) & 10'h3ff);
    end else inner_pos = (inner_pos + 1) & 24'hffffff;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("mismatch %s: got %h expected %h", what, got, exp);
    errors++;
  endtask

  always @(posedge clk_i) begin
    norm_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0)
        report_mismatch("unexpected beat", 64'(m_axis_tdata[31:0]), 64'd0);
      else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== e.value)
          report_mismatch("value", 64'(m_axis_tdata[31:0]), 64'(e.value));
        if (m_axis_tdata[41:32] !== e.chan)
          report_mismatch("channel", 64'(m_axis_tdata[41:32]), 64'(e.chan));
        if (m_axis_tuser !== e.sat)
          report_mismatch("saturated", 64'(m_axis_tuser), 64'(e.sat));
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send(input stim_row_t s);
    bit has; norm_res_t r;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {6'b0, s.x, s.vr, s.mu, s.bet, s.gam, s.ch};
    s_axis_tuser <= s.op;
    s_axis_tvalid <= 1'b1;
    normalize(s.op, s.ch, s.gam, s.bet, s.mu, s.vr, s.x, has, r);
    if (has) begin
      if (s.known && r !== s.res) report_mismatch("predictor", 64'(r), 64'(s.res));
      pending_q.push_back(r);
    end
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [24:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bni_pkg::CfgChannelCount) chan_cnt = val[10:0];
    else if (idx == bni_pkg::CfgInnerSize) inner_sz = val;
    else if (idx == bni_pkg::CfgEpsilon) eps = val[15:0];
  endtask

  function automatic stim_row_t load_row(input logic [9:0] ch, input logic signed [31:0] g,
                                         input logic signed [31:0] b,
                                         input logic signed [31:0] mu, input logic [31:0] vr);
    stim_row_t s;
    s = '{bni_pkg::OpLoad, ch, g, b, mu, vr, $urandom, 1'b0, '0};
    return s;
  endfunction

  function automatic stim_row_t smp_row(input logic signed [31:0] x, input bit k,
                                        input norm_res_t r);
    stim_row_t s;
    s = '{bni_pkg::OpSample, 10'($urandom), $urandom, $urandom, $urandom, $urandom,
          x, k, r};
    return s;
  endfunction

  function automatic logic [31:0] rnd_q();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return {{15{$urandom_range(1) ? 1'b1 : 1'b0}}, 17'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  stim_row_t dir_tab [$];

  initial begin
    stim_row_t s;
    int ncnt, nsz;
    chan_cnt = 1; inner_sz = 1; eps = 66;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // unit gain, zero mean, variance 1 less epsilon gives inv_std 1.0 exactly
    dir_tab.push_back(load_row(10'd0, 32'h10000, 32'h0, 32'h0, 32'h10000 - 32'd66));
    dir_tab.push_back(smp_row(32'h10000, 1'b0, '0));
    dir_tab.push_back(smp_row(32'h7fffffff, 1'b0, '0));
    dir_tab.push_back(smp_row(32'h80000000, 1'b0, '0));
    // near maximum variance: the difference clips and so does the offset
    dir_tab.push_back(load_row(10'd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                               32'hffffffbd));
    dir_tab.push_back(smp_row(32'h7fffffff, 1'b1, '{32'h7fffffff, 10'd0, 1'b1}));
    dir_tab.push_back(smp_row(32'h80000000, 1'b0, '0));
    dir_tab.push_back(load_row(10'h3ff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h0));
    dir_tab.push_back(load_row(10'd0, 32'h80000000, 32'h80000000, 32'h7fffffff,
                               32'hffffffff));
    dir_tab.push_back(smp_row(32'h80000000, 1'b1, '{32'h7fffffff, 10'd0, 1'b1}));
    dir_tab.push_back(smp_row(32'h0, 1'b0, '0));
    foreach (dir_tab[i]) send(dir_tab[i]);
    set_reg(bni_pkg::CfgEpsilon, 25'd0);
    send(load_row(10'd0, 32'h10000, 32'h0, 32'h0, 32'h0));
    send(smp_row(32'h1, 1'b1, '{32'h00007fff, 10'd0, 1'b0}));
    set_reg(bni_pkg::CfgEpsilon, 25'hffff);
    send(load_row(10'd0, $urandom, $urandom, $urandom, $urandom));
    send(smp_row($urandom, 1'b0, '0));
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 50; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 50; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      ncnt = (ph == 7) ? 1024 : (ph == 6 ? 0 : $urandom_range(1, 8));
      nsz  = (ph == 5) ? 0 : (ph == 4 ? 25'h1ffffff : $urandom_range(1, 5));
      set_reg(bni_pkg::CfgChannelCount, 25'((ph == 3) ? 11'h7ff : ncnt));
      set_reg(bni_pkg::CfgInnerSize, 25'(nsz));
      set_reg(bni_pkg::CfgEpsilon, 25'($urandom_range(1) ? 66 : $urandom_range(65535)));
      ncnt = (chan_cnt == 0) ? 1 : (chan_cnt > 1024 ? 1024 : chan_cnt);
      for (int c = 0; c < ncnt && c < 75; c++)
        send(load_row(10'(c), rnd_q(), rnd_q(), rnd_q(), rnd_q()));
      for (int k = 0; k < 75; k++) begin
        if ($urandom_range(19) == 0) begin
          s = load_row(10'($urandom_range(ncnt - 1)), rnd_q(), rnd_q(), rnd_q(), rnd_q());
          send(s);
        end else send(smp_row(rnd_q(), 1'b0, '0));
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0 && pending_q.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
